/* hw/rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants of the bitmap frame allocator
// Command and status codes, field widths and the lowest-clear-bit search.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int DEF_MAX_FRAMES = 4096;
   localparam int FRAME_SHIFT    = 12;
   localparam int WORD_BITS      = 32;
   localparam int BIT_POS_W      = 5;
   localparam int ADDR_W         = 32;
   localparam int FRAME_W        = ADDR_W - FRAME_SHIFT;
   localparam int COUNT_W        = 13;
   localparam int FREE_W         = 12;
   localparam int CMD_W          = 2;
   localparam int STATUS_W       = 2;

   localparam logic [COUNT_W-1:0]   COUNT_RESET = 13'd4096;
   localparam logic [WORD_BITS-1:0] FULL_WORD   = 32'hFFFF_FFFF;

   localparam logic [CMD_W-1:0] CMD_MARK_USED = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MARK_FREE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TEST      = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FIND      = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;

   // Control handed to the bit unit for one bitmap word.
   typedef struct packed {
      logic [CMD_W-1:0]     op;
      logic [BIT_POS_W-1:0] bit_pos;
   } bfa_bit_ctl_type;

   // What the bit unit reports about that word.
   typedef struct packed {
      logic [WORD_BITS-1:0] new_word;
      logic                 bit_used;
      logic                 word_full;
      logic [BIT_POS_W-1:0] zero_pos;
   } bfa_bit_res_type;

   // Binary search for the lowest clear bit: five halving steps.
   function automatic logic [BIT_POS_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] v);
      logic [WORD_BITS-1:0] w;
      logic [WORD_BITS-1:0] mask;
      logic [BIT_POS_W-1:0] pos;
      w   = v;
      pos = '0;
      for (int s = BIT_POS_W - 1; s >= 0; s--) begin
         mask = (32'h1 << (32'h1 << s)) - 32'h1;
         if (s == BIT_POS_W - 1) begin
            mask = 32'h0000_FFFF;
         end
         if ((w & mask) == mask) begin
            pos[s] = 1'b1;
            w      = w >> (32'h1 << s);
         end
      end
      return pos;
   endfunction

endpackage

/* hw/rtl/bfa_if.sv */
// ----------------------------------------------------------------------------
// bfa_if: handshake channels of the bitmap frame allocator
// Request, response and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
interface bfa_req_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [ADDR_W-1:0]  frame_address;

   modport source (output valid, output command, output frame_address, input ready);
   modport sink   (input valid, input command, input frame_address, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                frame_used;
   logic [FREE_W-1:0]   free_frame;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output frame_used, output free_frame, output status,
                   input ready);
   modport sink   (input valid, input frame_used, input free_frame, input status,
                   output ready);
endinterface

interface bfa_csr_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] frame_count;

   modport source (output valid, output frame_count, input ready);
   modport sink   (input valid, input frame_count, output ready);
endinterface

/* hw/rtl/bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: bitmap allocator for 4 KiB physical frames
// Mark used / mark free / test: the addressed word is read, then tested or rewritten
// (not for an address beyond the frame count); ready returns as the result is offered.
// Find first free: reads bitmap words in order until a free bit is found, at most
// min(frame_count, MAX_FRAMES)/32 words, one word per cycle through one port.
// Reset clears the whole bitmap in a pass during which no item is accepted;
// frame_count resets to 4096.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator import bfa_pkg::*; #(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
   input  logic     clock,
   input  logic     reset,
   bfa_req_if.sink  req_ch,
   bfa_rsp_if.source rsp_ch,
   bfa_csr_if.sink  csr_ch
);

   // Storage geometry. The word count follows from the frame limit, the
   // effective count is kept wide enough to hold both the register and the
   // limit itself.
   localparam int WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int WC_W   = $clog2(WORDS + 1);
   localparam int LIM_W  = $clog2(MAX_FRAMES + 1);
   localparam int EC_W   = (LIM_W > COUNT_W) ? LIM_W : COUNT_W;
   localparam int CMP_W  = (EC_W > FRAME_W) ? EC_W : FRAME_W;
   localparam int WSEL_W = FRAME_W - BIT_POS_W;

   localparam logic [EC_W-1:0] MAX_COUNT = EC_W'(MAX_FRAMES);
   localparam logic [AW-1:0]   LAST_WORD = AW'(WORDS - 1);

   // Sequencer states.
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_LOOK  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [WC_W-1:0]      words_ff, words_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [BIT_POS_W-1:0] bitpos_ff, bitpos_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   // Result waiting for the output register.
   logic                 res_used_ff, res_used_in;
   logic [FREE_W-1:0]    res_free_ff, res_free_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;

   // Output register toward the response channel.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_used_ff, rsp_used_in;
   logic [FREE_W-1:0]    rsp_free_ff, rsp_free_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [WORD_BITS-1:0] ram_rd_data;

   bfa_bit_ctl_type      bu_ctl;
   bfa_bit_res_type      bu_res;

   logic [EC_W-1:0]      count_ext;
   logic [EC_W-1:0]      eff_count;
   logic [EC_W-1:0]      eff_words_wide;
   logic [WC_W-1:0]      scan_words;
   logic [FRAME_W-1:0]   req_frame;
   logic [WSEL_W-1:0]    req_word_sel;
   logic                 req_out_of_range;
   logic                 req_take;
   logic [WC_W-1:0]      next_scan;
   logic [WORD_BITS-1:0] found_wide;

   bfa_bitmap_ram #(
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign bu_ctl.op      = cmd_ff;
   assign bu_ctl.bit_pos = bitpos_ff;

   bfa_bit_unit u_bit_unit (
      .word (ram_rd_data),
      .ctl  (bu_ctl),
      .res  (bu_res)
   );

   // A count above the frame limit behaves as the limit. The search covers
   // only whole words below the effective count.
   assign count_ext      = EC_W'(count_ff);
   assign eff_count      = (count_ext > MAX_COUNT) ? MAX_COUNT : count_ext;
   assign eff_words_wide = eff_count >> BIT_POS_W;
   assign scan_words     = eff_words_wide[WC_W-1:0];

   // Frame index of the request and the bitmap word that holds it. A frame
   // below the effective count always lies inside the bitmap.
   assign req_frame        = req_ch.frame_address[ADDR_W-1:FRAME_SHIFT];
   assign req_word_sel     = req_frame[FRAME_W-1:BIT_POS_W];
   assign req_out_of_range = CMP_W'(req_frame) >= CMP_W'(eff_count);

   assign req_take  = req_ch.valid && req_ch.ready;
   assign next_scan = WC_W'(ptr_ff) + WC_W'(1);

   // Frame index of the free bit found in the current scan word, cut to the
   // width of the result field.
   assign found_wide = WORD_BITS'({ptr_ff, bu_res.zero_pos});

   // The configuration register is to be written only while the block is idle; the block itself does not enforce this.
   assign csr_ch.ready = 1'b1;
   assign count_in     = (csr_ch.valid && csr_ch.ready) ? csr_ch.frame_count : count_ff;

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      words_in      = words_ff;
      cmd_in        = cmd_ff;
      bitpos_in     = bitpos_ff;
      res_used_in   = res_used_ff;
      res_free_in   = res_free_ff;
      res_status_in = res_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_data   = bu_res.new_word;
      ram_rd_addr   = ptr_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_used_in   = rsp_used_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_CLEAR: begin
            // One word cleared per cycle after reset.
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
            if (ptr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_take) begin
               cmd_in      = req_ch.command;
               res_used_in = 1'b0;
               res_free_in = '0;
               if (req_ch.command == CMD_FIND) begin
                  if (scan_words == '0) begin
                     res_status_in = STATUS_NONE;
                     state_in      = S_DONE;
                  end else begin
                     ram_rd_addr   = '0;
                     ptr_in        = '0;
                     words_in      = scan_words;
                     res_status_in = STATUS_OK;
                     state_in      = S_SCAN;
                  end
               end else if (req_out_of_range) begin
                  // Ignored: the bitmap stays as it is.
                  res_status_in = STATUS_RANGE;
                  state_in      = S_DONE;
               end else begin
                  ram_rd_addr   = req_word_sel[AW-1:0];
                  ptr_in        = req_word_sel[AW-1:0];
                  bitpos_in     = req_frame[BIT_POS_W-1:0];
                  res_status_in = STATUS_OK;
                  state_in      = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            // Read-modify-write of the addressed word, or a plain test.
            if (cmd_ff == CMD_MARK_USED || cmd_ff == CMD_MARK_FREE) begin
               ram_wr_en = 1'b1;
            end
            res_used_in = (cmd_ff == CMD_TEST) ? bu_res.bit_used : 1'b0;
            state_in    = S_DONE;
         end
         S_SCAN: begin
            // The word read last cycle is checked while the next is fetched.
            if (!bu_res.word_full) begin
               res_free_in = found_wide[FREE_W-1:0];
               state_in    = S_DONE;
            end else if (next_scan == words_ff) begin
               res_status_in = STATUS_NONE;
               state_in      = S_DONE;
            end else begin
               ptr_in      = ptr_ff + AW'(1);
               ram_rd_addr = ptr_ff + AW'(1);
            end
         end
         S_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_used_in   = res_used_ff;
               rsp_free_in   = res_free_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff      <= words_in;
      cmd_ff        <= cmd_in;
      bitpos_ff     <= bitpos_in;
      res_used_ff   <= res_used_in;
      res_free_ff   <= res_free_in;
      res_status_ff <= res_status_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.frame_used = rsp_used_ff;
   assign rsp_ch.free_frame = rsp_free_ff;
   assign rsp_ch.status     = rsp_status_ff;

endmodule

/* hw/rtl/bfa_bitmap_ram.sv */
// ----------------------------------------------------------------------------
// bfa_bitmap_ram: bitmap word storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_bitmap_ram import bfa_pkg::*; #(
   parameter int DEPTH = DEF_MAX_FRAMES / WORD_BITS,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bfa_bit_unit.sv */
// ----------------------------------------------------------------------------
// bfa_bit_unit: shared word operator
// Sets, clears or tests one bit of a bitmap word and finds its lowest free bit.
// ----------------------------------------------------------------------------
module bfa_bit_unit import bfa_pkg::*; (
   input  logic [WORD_BITS-1:0] word,
   input  bfa_bit_ctl_type      ctl,
   output bfa_bit_res_type      res
);

   logic [WORD_BITS-1:0] bit_mask;

   assign bit_mask = 32'h1 << ctl.bit_pos;

   always_comb begin
      case (ctl.op)
         CMD_MARK_USED: res.new_word = word | bit_mask;
         CMD_MARK_FREE: res.new_word = word & ~bit_mask;
         default:       res.new_word = word;
      endcase
      res.bit_used  = word[ctl.bit_pos];
      res.word_full = (word == FULL_WORD);
      res.zero_pos  = lowest_zero(word);
   end

endmodule
